@@ sv/kce_pkg.sv @@
// Package for the knapsack cipher engine: request codes, register indexes,
// state types and the key-table write bundle. No dependencies.
package kce_pkg;

    localparam int KeyW    = 24;
    localparam int PubW    = 28;
    localparam int ModW    = 28;
    localparam int CipherW = 32;
    localparam int BlockW  = 16;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_ENCRYPT = 2'd1,
        REQ_DECRYPT = 2'd2,
        REQ_UNKNOWN = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        REG_ELEMENTS   = 2'd0,
        REG_MODULUS    = 2'd1,
        REG_MULTIPLIER = 2'd2,
        REG_INVERSE    = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_REDUCE,
        MM_MUL
    } t_mm_state;

    typedef struct packed {
        logic            en;
        logic [KeyW-1:0] priv;
        logic [PubW-1:0] pub;
    } t_key_wr;

endpackage

@@ sv/kce_modmul.sv @@
// Bit-serial modular multiplier: reduces the wide operand one bit a cycle,
// then runs an interleaved shift-and-add over the narrow operand.
// Depends on kce_pkg.
module kce_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [kce_pkg::CipherW-1:0] i_a,
    input  logic [kce_pkg::ModW-1:0]  i_b,
    input  logic [kce_pkg::ModW:0]    i_mod,
    output logic                      o_done,
    output logic [kce_pkg::ModW-1:0]  o_result
);
    import kce_pkg::*;

    t_mm_state           r_state, n_state;
    logic [CipherW-1:0]  r_a, n_a;
    logic [ModW-1:0]     r_b, n_b;
    logic [ModW-1:0]     r_r, n_r;
    logic [ModW-1:0]     r_ap, n_ap;
    logic [ModW:0]       r_m, n_m;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_done, n_done;

    logic [ModW:0] red_t, red_v;
    logic [ModW:0] dbl_t, dbl_v, add_t, add_v;

    always_comb begin
        // Restoring reduction step: the remainder stays below the modulus.
        red_t = {r_r, r_a[CipherW-1]};
        red_v = (red_t >= r_m) ? red_t - r_m : red_t;
        // Interleaved step: double, reduce, add the reduced operand, reduce.
        dbl_t = {r_r, 1'b0};
        dbl_v = (dbl_t >= r_m) ? dbl_t - r_m : dbl_t;
        add_t = dbl_v + (r_b[ModW-1] ? {1'b0, r_ap} : '0);
        add_v = (add_t >= r_m) ? add_t - r_m : add_t;
    end

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_r     = r_r;
        n_ap    = r_ap;
        n_m     = r_m;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            MM_IDLE: begin
                if (i_start) begin
                    n_a     = i_a;
                    n_b     = i_b;
                    n_m     = i_mod;
                    n_r     = '0;
                    n_cnt   = 5'(CipherW - 1);
                    n_state = MM_REDUCE;
                end
            end
            MM_REDUCE: begin
                n_r = red_v[ModW-1:0];
                n_a = {r_a[CipherW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_ap    = red_v[ModW-1:0];
                    n_r     = '0;
                    n_cnt   = 5'(ModW - 1);
                    n_state = MM_MUL;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            MM_MUL: begin
                n_r = add_v[ModW-1:0];
                n_b = {r_b[ModW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = MM_IDLE;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            default: n_state = MM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MM_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_a  <= n_a;
        r_b  <= n_b;
        r_r  <= n_r;
        r_ap <= n_ap;
        r_m  <= n_m;
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

@@ sv/kce_keystore.sv @@
// Private and public key tables with one write port and one registered
// read port. Depends on kce_pkg.
module kce_keystore #(
    parameter int MAX_ELEMENTS = 16,
    parameter int AW           = 4
) (
    input  logic                     i_clk,
    input  kce_pkg::t_key_wr         i_wr,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [kce_pkg::KeyW-1:0] o_rd_priv,
    output logic [kce_pkg::PubW-1:0] o_rd_pub
);
    import kce_pkg::*;

    logic [KeyW-1:0] r_priv_mem [MAX_ELEMENTS];
    logic [PubW-1:0] r_pub_mem  [MAX_ELEMENTS];
    logic [KeyW-1:0] r_rd_priv;
    logic [PubW-1:0] r_rd_pub;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_priv_mem[i_wr_addr] <= i_wr.priv;
            r_pub_mem[i_wr_addr]  <= i_wr.pub;
        end
        r_rd_priv <= r_priv_mem[i_rd_addr];
        r_rd_pub  <= r_pub_mem[i_rd_addr];
    end

    assign o_rd_priv = r_rd_priv;
    assign o_rd_pub  = r_rd_pub;

endmodule

@@ sv/knapsack_cipher_engine_core.sv @@
// Knapsack cipher engine, one transaction in flight at a time; n is the clamped element count.
// A load or a decrypt first runs the bit-serial modular multiplier (32 reduce and 28 multiply
// steps); an encrypt goes straight to the table walk, as does a decrypt after the multiplier.
// A new transaction is taken the cycle after a result is registered; while a result waits,
// the next one holds in its final state.
// Synchronous active-low reset restores register defaults and idles control; tables persist.
module knapsack_cipher_engine_core #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [3:0]                  i_key_index,
    input  logic [kce_pkg::KeyW-1:0]    i_key_value,
    input  logic [kce_pkg::BlockW-1:0]  i_plain_bits,
    input  logic [kce_pkg::CipherW-1:0] i_cipher_value,
    // Output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [kce_pkg::CipherW-1:0] o_cipher_sum,
    output logic [kce_pkg::BlockW-1:0]  o_recovered_bits,
    output logic                        o_no_subset,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [3:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import kce_pkg::*;

    localparam int AW         = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int BlockLimit = (MAX_ELEMENTS < 16) ? MAX_ELEMENTS : 16;

    // Configuration registers, written over the APB-style port.
    logic [4:0]      r_elements;
    logic [ModW-1:0] r_modulus;
    logic [ModW-1:0] r_multiplier;
    logic [ModW-1:0] r_inverse;

    // Sequencer state and per-transaction working registers.
    t_state              r_state, n_state;
    t_req                r_req, n_req;
    logic                r_idx_ok, n_idx_ok;
    logic [3:0]          r_idx, n_idx;
    logic [KeyW-1:0]     r_kval, n_kval;
    logic [BlockW-1:0]   r_plain, n_plain;
    logic [ModW-1:0]     r_rem, n_rem;
    logic [CipherW-1:0]  r_sum, n_sum;
    logic [BlockW-1:0]   r_bits, n_bits;
    logic [3:0]          r_j, n_j;
    logic [3:0]          r_pos, n_pos;
    logic [3:0]          r_pos_d, n_pos_d;
    logic                r_vld, n_vld;
    logic [4:0]          r_left, n_left;

    // Output register.
    logic                r_out_valid, n_out_valid;
    logic [CipherW-1:0]  r_out_sum, n_out_sum;
    logic [BlockW-1:0]   r_out_bits, n_out_bits;
    logic                r_out_flag, n_out_flag;

    logic                in_accept, cfg_write, out_free;
    logic [4:0]          active_n;
    logic [3:0]          last_pos;
    logic [ModW:0]       mod_eff;
    logic                mm_start, mm_done;
    logic [CipherW-1:0]  mm_a;
    logic [ModW-1:0]     mm_b, mm_result;
    t_key_wr             key_wr;
    logic [KeyW-1:0]     rd_priv;
    logic [PubW-1:0]     rd_pub;
    t_req                in_req;

    assign in_req     = t_req'(i_req_type);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;

    // Element count clamped to the range the tables and the block width support.
    always_comb begin
        if (r_elements == '0) begin
            active_n = 5'd1;
        end else if (r_elements > 5'(BlockLimit)) begin
            active_n = 5'(BlockLimit);
        end else begin
            active_n = r_elements;
        end
        last_pos = 4'(active_n - 5'd1);
    end

    // A zero modulus means no reduction; reducing by two to the 28 keeps the low 28 bits.
    assign mod_eff = (r_modulus == '0) ? {1'b1, {ModW{1'b0}}} : {1'b0, r_modulus};

    // Configuration registers and read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elements   <= 5'd8;
            r_modulus    <= 28'd2;
            r_multiplier <= 28'd1;
            r_inverse    <= 28'd1;
        end else if (cfg_write) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_ELEMENTS:   r_elements   <= pwdata[4:0];
                REG_MODULUS:    r_modulus    <= pwdata[ModW-1:0];
                REG_MULTIPLIER: r_multiplier <= pwdata[ModW-1:0];
                REG_INVERSE:    r_inverse    <= pwdata[ModW-1:0];
                default:        r_elements   <= r_elements;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_ELEMENTS:   prdata = {27'd0, r_elements};
            REG_MODULUS:    prdata = {4'd0, r_modulus};
            REG_MULTIPLIER: prdata = {4'd0, r_multiplier};
            REG_INVERSE:    prdata = {4'd0, r_inverse};
            default:        prdata = '0;
        endcase
    end

    // The multiplier is started straight from the accepted transaction: a load forms the
    // public entry, a decrypt undoes the multiplier on the ciphertext.
    assign mm_start = in_accept && (in_req == REQ_LOAD || in_req == REQ_DECRYPT);
    assign mm_a     = (in_req == REQ_LOAD) ? {8'd0, i_key_value} : i_cipher_value;
    assign mm_b     = (in_req == REQ_LOAD) ? r_multiplier : r_inverse;

    kce_modmul u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_mod    (mod_eff),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    // Key tables are written when the public entry is ready, and only for an index
    // that exists.
    always_comb begin
        key_wr.en   = (r_state == ST_MUL) && mm_done && (r_req == REQ_LOAD) && r_idx_ok;
        key_wr.priv = r_kval;
        key_wr.pub  = mm_result;
    end

    kce_keystore #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW)
    ) u_keystore (
        .i_clk     (i_clk),
        .i_wr      (key_wr),
        .i_wr_addr (AW'(r_idx)),
        .i_rd_addr (AW'(r_j)),
        .o_rd_priv (rd_priv),
        .o_rd_pub  (rd_pub)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // Sequencer. The walk issues one table read per cycle and consumes the registered data
    // in the following cycle, so issue and use overlap. Encrypt runs from entry 0 upwards with the
    // block bit position running down from n-1; decrypt runs from the top entry down, with
    // the greedy subtraction filling the recovered block from bit 0 upwards.
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_idx_ok    = r_idx_ok;
        n_idx       = r_idx;
        n_kval      = r_kval;
        n_plain     = r_plain;
        n_rem       = r_rem;
        n_sum       = r_sum;
        n_bits      = r_bits;
        n_j         = r_j;
        n_pos       = r_pos;
        n_pos_d     = r_pos_d;
        n_vld       = 1'b0;
        n_left      = r_left;
        n_out_valid = (r_out_valid && i_out_stall);
        n_out_sum   = r_out_sum;
        n_out_bits  = r_out_bits;
        n_out_flag  = r_out_flag;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_req    = in_req;
                    n_idx    = i_key_index;
                    n_idx_ok = (32'(i_key_index) < 32'(MAX_ELEMENTS));
                    n_kval   = i_key_value;
                    n_plain  = i_plain_bits;
                    n_sum    = '0;
                    n_bits   = '0;
                    n_rem    = '0;
                    n_left   = active_n;
                    n_j      = '0;
                    n_pos    = last_pos;
                    unique case (in_req)
                        REQ_LOAD, REQ_DECRYPT: n_state = ST_MUL;
                        REQ_ENCRYPT:           n_state = ST_WALK;
                        default:               n_state = ST_DONE;
                    endcase
                end
            end
            ST_MUL: begin
                if (mm_done) begin
                    if (r_req == REQ_DECRYPT) begin
                        n_rem   = mm_result;
                        n_j     = last_pos;
                        n_pos   = '0;
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (r_left != '0) begin
                    n_vld   = 1'b1;
                    n_pos_d = r_pos;
                    n_left  = r_left - 5'd1;
                    if (r_req == REQ_ENCRYPT) begin
                        n_j   = r_j + 4'd1;
                        n_pos = r_pos - 4'd1;
                    end else begin
                        n_j   = r_j - 4'd1;
                        n_pos = r_pos + 4'd1;
                    end
                end
                if (r_vld) begin
                    if (r_req == REQ_ENCRYPT) begin
                        if (r_plain[r_pos_d]) begin
                            n_sum = r_sum + {4'd0, rd_pub};
                        end
                    end else if ({4'd0, rd_priv} <= r_rem) begin
                        n_rem           = r_rem - {4'd0, rd_priv};
                        n_bits[r_pos_d] = 1'b1;
                    end
                end
                if (r_left == '0 && !r_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_sum   = (r_req == REQ_ENCRYPT) ? r_sum : '0;
                    n_out_bits  = (r_req == REQ_DECRYPT) ? r_bits : '0;
                    n_out_flag  = (r_req == REQ_DECRYPT) && (r_rem != '0);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_req       <= REQ_UNKNOWN;
            r_vld       <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req       <= n_req;
            r_vld       <= n_vld;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_idx_ok   <= n_idx_ok;
        r_idx      <= n_idx;
        r_kval     <= n_kval;
        r_plain    <= n_plain;
        r_rem      <= n_rem;
        r_sum      <= n_sum;
        r_bits     <= n_bits;
        r_j        <= n_j;
        r_pos      <= n_pos;
        r_pos_d    <= n_pos_d;
        r_out_sum  <= n_out_sum;
        r_out_bits <= n_out_bits;
        r_out_flag <= n_out_flag;
    end

    assign o_out_valid      = r_out_valid;
    assign o_cipher_sum     = r_out_sum;
    assign o_recovered_bits = r_out_bits;
    assign o_no_subset      = r_out_flag;

endmodule

@@ tb/knapsack_cipher_engine_core_tb.sv @@
// Self-checking testbench for the knapsack cipher engine core: key loads, encryption and
// decryption, checked against a predictor written in SystemVerilog.
// Depends on kce_pkg and knapsack_cipher_engine_core only.
module knapsack_cipher_engine_core_tb;
    import kce_pkg::*;

    localparam int          NumEntries  = 16;
    localparam int          TargetItems = 1800;
    localparam logic [31:0] Mask28      = 32'h0FFF_FFFF;
    localparam logic [31:0] Mask24      = 32'h00FF_FFFF;

    // Clock, reset and all block inputs start at known values.
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic [1:0]           req_type     = '0;
    logic [3:0]           key_index    = '0;
    logic [KeyW-1:0]      key_value    = '0;
    logic [BlockW-1:0]    plain_bits   = '0;
    logic [CipherW-1:0]   cipher_value = '0;
    logic                 out_stall    = 1'b1;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [3:0]           paddr        = '0;
    logic [31:0]          pwdata       = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic [CipherW-1:0]   cipher_sum;
    logic [BlockW-1:0]    recovered_bits;
    logic                 no_subset;
    logic [31:0]          prdata;
    logic                 pready;

    knapsack_cipher_engine_core #(
        .MAX_ELEMENTS(NumEntries)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_key_index     (key_index),
        .i_key_value     (key_value),
        .i_plain_bits    (plain_bits),
        .i_cipher_value  (cipher_value),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_cipher_sum    (cipher_sum),
        .o_recovered_bits(recovered_bits),
        .o_no_subset     (no_subset),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // One expected result transaction, tagged with the request that caused it so that a
    // mismatch report says what kind of work went wrong.
    typedef struct {
        logic [CipherW-1:0] cipher_sum;
        logic [BlockW-1:0]  recovered_bits;
        logic               no_subset;
        t_req               kind;
    } t_cipher_result;

    t_cipher_result expected_results[$];

    // The predictor's own copy of the registers, initialised to their reset values, and of
    // the two key tables. Every entry is loaded before anything reads it, so the tables
    // need no initial value here.
    logic [4:0]      cfg_elements   = 5'd8;
    logic [ModW-1:0] cfg_modulus    = 28'd2;
    logic [ModW-1:0] cfg_multiplier = 28'd1;
    logic [ModW-1:0] cfg_inverse    = 28'd1;
    logic [KeyW-1:0] priv_keys [NumEntries];
    logic [PubW-1:0] pub_keys  [NumEntries];

    int unsigned err_count     = 0;
    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 60;
    int unsigned hold_left     = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    // Safety net: the slowest legal run is several times shorter than this.
    initial begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // Effective block length: zero counts as one entry, anything above the table size is
    // clamped to the table size.
    function automatic int unsigned block_len();
        if (cfg_elements == 5'd0) begin
            return 1;
        end
        if (cfg_elements > NumEntries) begin
            return NumEntries;
        end
        return int'(cfg_elements);
    endfunction

    // Reduction modulo the configured modulus. A zero modulus means no reduction at all,
    // just the low 28 bits of the value.
    function automatic logic [31:0] reduce_mod(logic [63:0] x);
        logic [63:0] m;
        m = {36'd0, cfg_modulus};
        if (cfg_modulus == '0) begin
            return {4'd0, x[27:0]};
        end
        return 32'(x % m);
    endfunction

    // Works out the result of one request and applies a key load to the tables.
    function automatic t_cipher_result predict_request(t_req rq, logic [3:0] idx,
                                                       logic [KeyW-1:0] kv,
                                                       logic [BlockW-1:0] pb,
                                                       logic [CipherW-1:0] cv);
        t_cipher_result r;
        int unsigned    n;
        logic [31:0]    rem;
        logic [31:0]    e;
        r.cipher_sum     = '0;
        r.recovered_bits = '0;
        r.no_subset      = 1'b0;
        r.kind           = rq;
        n = block_len();
        case (rq)
            REQ_LOAD: begin
                priv_keys[idx] = kv;
                pub_keys[idx]  = 28'(reduce_mod({40'd0, kv} * {36'd0, cfg_multiplier}));
            end
            REQ_ENCRYPT: begin
                // The most significant used bit of the block selects entry zero.
                for (int k = 0; k < n; k++) begin
                    if (pb[n - 1 - k]) begin
                        r.cipher_sum = r.cipher_sum + {4'd0, pub_keys[k]};
                    end
                end
            end
            REQ_DECRYPT: begin
                // Greedy walk from the highest entry down. A zero entry is always taken.
                rem = reduce_mod({32'd0, cv} * {36'd0, cfg_inverse});
                for (int k = n; k > 0; k--) begin
                    e = {8'd0, priv_keys[k - 1]};
                    if (e <= rem) begin
                        rem = rem - e;
                        r.recovered_bits[n - k] = 1'b1;
                    end
                end
                r.no_subset = (rem != 0);
            end
            default: begin
                // An unknown request is ignored and answers all zero.
            end
        endcase
        return r;
    endfunction

    // Helpers used to build well-formed knapsacks for the random sessions.
    function automatic longint gcd_of(longint a, longint b);
        longint t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint inverse_mod(longint a, longint m);
        longint t;
        longint newt;
        longint r;
        longint newr;
        longint q;
        longint tmp;
        t    = 0;
        newt = 1;
        r    = m;
        newr = a;
        while (newr != 0) begin
            q    = r / newr;
            tmp  = t - q * newt;
            t    = newt;
            newt = tmp;
            tmp  = r - q * newr;
            r    = newr;
            newr = tmp;
        end
        if (t < 0) begin
            t = t + m;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------------------------

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch, %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // Every result transaction accepted by the testbench is compared with the oldest
    // expectation. Outputs are sampled at the clock edge, before the block updates them.
    always @(posedge clk) begin : check_results
        t_cipher_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", cipher_sum, 0);
            end else begin
                want = expected_results.pop_front();
                if (cipher_sum !== want.cipher_sum) begin
                    report_mismatch({want.kind.name(), " cipher_sum"},
                                    cipher_sum, want.cipher_sum);
                end
                if (recovered_bits !== want.recovered_bits) begin
                    report_mismatch({want.kind.name(), " recovered_bits"},
                                    recovered_bits, want.recovered_bits);
                end
                if (no_subset !== want.no_subset) begin
                    report_mismatch({want.kind.name(), " no_subset"},
                                    no_subset, want.no_subset);
                end
            end
        end
    end

    // Receiver side. A requested hold-off is counted down here, cycle by cycle; otherwise
    // the stall follows the current idle percentage.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus primitives
    // ------------------------------------------------------------------------------------

    // Offers one request transaction, holds it steady while the block stalls, and records
    // the prediction at the edge where it is accepted. Valid is left high on return so that
    // a following request can go out back to back.
    task automatic send_request(t_req rq, logic [3:0] idx, logic [KeyW-1:0] kv,
                                logic [BlockW-1:0] pb, logic [CipherW-1:0] cv);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq;
        key_index    <= idx;
        key_value    <= kv;
        plain_bits   <= pb;
        cipher_value <= cv;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        expected_results.push_back(predict_request(rq, idx, kv, pb, cv));
    endtask

    // Shorthands for requests whose other fields carry random content.
    task automatic send_load(logic [3:0] idx, logic [KeyW-1:0] kv);
        send_request(REQ_LOAD, idx, kv, 16'($urandom), $urandom);
    endtask

    task automatic send_encrypt(logic [BlockW-1:0] pb);
        send_request(REQ_ENCRYPT, 4'($urandom), 24'($urandom), pb, $urandom);
    endtask

    task automatic send_decrypt(logic [CipherW-1:0] cv);
        send_request(REQ_DECRYPT, 4'($urandom), 24'($urandom), 16'($urandom), cv);
    endtask

    // Lowers valid and waits until every outstanding result has been taken. Each request
    // produces a result, so the block is idle once the store of expectations is empty.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the bus is left idle after each transfer.
    task automatic cfg_write(t_reg_idx reg_sel, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_sel)
            REG_ELEMENTS:   cfg_elements   = value[4:0];
            REG_MODULUS:    cfg_modulus    = value[27:0];
            REG_MULTIPLIER: cfg_multiplier = value[27:0];
            default:        cfg_inverse    = value[27:0];
        endcase
        @(posedge clk);
    endtask

    // APB read, compared with the expected value. Read data is sampled mid-way through the
    // access cycle so that it does not race the clock edge.
    task automatic cfg_check(t_reg_idx reg_sel, logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            report_mismatch({"readback of ", reg_sel.name()}, got, want);
        end
        @(posedge clk);
    endtask

    // Writes all four registers while the block is idle, then reads them back.
    task automatic apply_config(logic [31:0] elem, logic [31:0] modv, logic [31:0] mulv,
                                logic [31:0] invv);
        drain_pipeline();
        cfg_write(REG_ELEMENTS, elem);
        cfg_write(REG_MODULUS, modv);
        cfg_write(REG_MULTIPLIER, mulv);
        cfg_write(REG_INVERSE, invv);
        cfg_check(REG_ELEMENTS, elem & 32'h1F);
        cfg_check(REG_MODULUS, modv & Mask28);
        cfg_check(REG_MULTIPLIER, mulv & Mask28);
        cfg_check(REG_INVERSE, invv & Mask28);
    endtask

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // The registers must come out of reset at their documented defaults.
    task automatic test_register_reset();
        cfg_check(REG_ELEMENTS, 32'd8);
        cfg_check(REG_MODULUS, 32'd2);
        cfg_check(REG_MULTIPLIER, 32'd1);
        cfg_check(REG_INVERSE, 32'd1);
    endtask

    // Fills every table entry under the reset settings, with a zero entry and an all-ones
    // entry among them. Nothing later ever reads an entry that was not written here.
    task automatic test_key_load();
        for (int k = 0; k < NumEntries; k++) begin
            if (k == 0) begin
                send_load(4'(k), '0);
            end else if (k == NumEntries - 1) begin
                send_load(4'(k), 24'hFF_FFFF);
            end else begin
                send_load(4'(k), 24'($urandom));
            end
        end
    endtask

    // Field extremes for each kind of request, including an unknown request type with
    // every field at its maximum, and block bits above the block length set.
    task automatic test_boundary_requests();
        send_request(REQ_ENCRYPT, 4'hF, 24'hFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_ENCRYPT, 4'h0, 24'h00_0000, 16'hFFFF, 32'h0000_0000);
        send_request(REQ_DECRYPT, 4'hF, 24'hFF_FFFF, 16'hFFFF, 32'h0000_0000);
        send_request(REQ_DECRYPT, 4'h0, 24'h00_0000, 16'h0000, 32'hFFFF_FFFF);
        send_request(REQ_UNKNOWN, 4'hF, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // Register extremes: element count zero and above the table size, a zero modulus,
    // the largest modulus, multipliers and inverses at zero and at their maxima. Junk above
    // the register widths must be dropped by the block.
    task automatic test_config_extremes();
        apply_config(32'hFFFF_FFE0, 32'hF000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_load(4'd0, 24'hFF_FFFF);
        send_encrypt(16'hFFFF);
        send_decrypt(32'hFFFF_FFFF);
        apply_config(32'd31, Mask28, 32'd0, 32'd0);
        send_load(4'd5, 24'hFF_FFFF);
        send_encrypt(16'hFFFF);
        send_decrypt(32'hFFFF_FFFF);
        apply_config(32'd16, Mask28, 32'd1, 32'd1);
        send_decrypt(32'h0FFF_FFFE);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering requests,
    // so that the output register fills and the block has to stall its input.
    task automatic test_input_backpressure();
        int unsigned saved_send;
        int unsigned saved_recv;
        saved_send = send_idle_pct;
        saved_recv = recv_idle_pct;
        drain_pipeline();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 400;
        for (int j = 0; j < 8; j++) begin
            if (j % 2 == 0) begin
                send_encrypt(16'($urandom));
            end else begin
                send_decrypt($urandom);
            end
        end
        drain_pipeline();
        send_idle_pct = saved_send;
        recv_idle_pct = saved_recv;
    endtask

    // Random sessions. Most set up a proper knapsack (superincreasing private key, modulus
    // above its sum, a multiplier coprime to the modulus and its true inverse), load it and
    // then encrypt blocks and decrypt the ciphertexts again, so the greedy walk reaches a
    // zero remainder. Random ciphertexts, stray key loads, unknown requests and nonsense
    // settings make up the rest.
    task automatic test_random_sessions();
        int unsigned     done_items;
        int unsigned     sess_len;
        int unsigned     n;
        int unsigned     r;
        logic [31:0]     total;
        logic [31:0]     e;
        logic [31:0]     m;
        logic [31:0]     w;
        logic [31:0]     winv;
        logic [31:0]     elem_w;
        logic [31:0]     cv;
        logic [KeyW-1:0] keys [NumEntries];
        logic [31:0]     backlog[$];
        done_items = 0;
        while (done_items < TargetItems) begin
            if (done_items < TargetItems / 3) begin
                send_idle_pct = 36;
                recv_idle_pct = 60;
            end else if (done_items < 2 * TargetItems / 3) begin
                send_idle_pct = 60;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            backlog.delete();

            // Each entry exceeds the sum of those below it, bar a first entry of zero; the growth
            // is kept small enough that sixteen entries still fit in 24 bits.
            n     = $urandom_range(1, NumEntries);
            total = 0;
            for (int k = 0; k < NumEntries; k++) begin
                if (k < n) begin
                    if (k == 0 && $urandom_range(0, 7) == 0) begin
                        e = 0;
                    end else begin
                        e = total + 1 + ($urandom & ((32'd1 << $urandom_range(0, 6)) - 1));
                    end
                    keys[k] = e[KeyW-1:0];
                    total   = total + e;
                end else begin
                    keys[k] = 24'($urandom);
                end
            end
            m = total + 1 + $urandom_range(0, 32'h07FF_FFFF);
            if (m > Mask28 || $urandom_range(0, 9) == 0) begin
                m = Mask28;
            end
            do begin
                w = $urandom_range(1, m - 1);
            end while (gcd_of(longint'(w), longint'(m)) != 1);
            winv   = 32'(inverse_mod(longint'(w), longint'(m)));
            elem_w = n;
            if (n == NumEntries && $urandom_range(0, 1) == 1) begin
                elem_w = $urandom_range(17, 31);
            end
            if ($urandom_range(0, 9) == 0) begin
                elem_w = $urandom_range(0, 31);
                m      = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, Mask28);
                w      = $urandom_range(0, Mask28);
                winv   = $urandom_range(0, Mask28);
            end
            apply_config($urandom_range(0, 1) ? elem_w : (elem_w | ($urandom << 5)),
                         m, w, winv);

            for (int k = 0; k < NumEntries; k++) begin
                send_load(4'(k), keys[k]);
            end
            done_items += NumEntries;

            sess_len = $urandom_range(20, 60);
            for (int j = 0; j < sess_len; j++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    send_encrypt(16'($urandom));
                    backlog.push_back(expected_results[$].cipher_sum);
                end else if (r < 75 && backlog.size() != 0) begin
                    send_decrypt(backlog.pop_front());
                end else if (r < 90) begin
                    cv = $urandom;
                    if ($urandom_range(0, 1) == 1 && m > 1) begin
                        cv = $urandom_range(0, m - 1);
                    end
                    send_decrypt(cv);
                end else if (r < 96) begin
                    send_load(4'($urandom), 24'($urandom));
                end else begin
                    send_request(REQ_UNKNOWN, 4'($urandom), 24'($urandom), 16'($urandom),
                                 $urandom);
                    continue;
                end
                done_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_key_load();
        test_boundary_requests();
        test_config_extremes();
        test_input_backpressure();
        test_random_sessions();

        // Let any last result drain, then allow a full decrypt latency for stray output.
        drain_pipeline();
        repeat (100) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
